/* hw/rtl/ssrf_pkg.sv */
// ============================================================================
// ssrf_pkg - servo setpoint register file package
// Address map, reset values, shared widths and the structs passed between
// the register file and its setpoint arithmetic.
// ============================================================================
`default_nettype none

package ssrf_pkg;

    // Address map
    localparam logic [4:0] ADDR_GAIN_FIRST = 5'd0;
    localparam logic [4:0] ADDR_GAIN_LAST  = 5'd8;
    localparam logic [4:0] ADDR_CUR_I      = 5'd1;
    localparam logic [4:0] ADDR_VEL_I      = 5'd4;
    localparam logic [4:0] ADDR_ANG_I      = 5'd7;
    localparam logic [4:0] ADDR_CENTER     = 5'd9;
    localparam logic [4:0] ADDR_SCALE      = 5'd10;
    localparam logic [4:0] ADDR_INVERT     = 5'd11;
    localparam logic [4:0] ADDR_DRIVE      = 5'd12;
    localparam logic [4:0] ADDR_CURRENT    = 5'd13;
    localparam logic [4:0] ADDR_VELOCITY   = 5'd14;
    localparam logic [4:0] ADDR_ANGLE      = 5'd15;
    localparam logic [4:0] ADDR_INIT       = 5'd16;

    localparam int GAIN_COUNT = 9;
    localparam int GAIN_IDX_W = $clog2(GAIN_COUNT);

    // Access kind
    localparam logic ACTION_READ  = 1'b0;
    localparam logic ACTION_WRITE = 1'b1;

    // Init levels at which each loop switches on
    localparam logic [7:0] LEVEL_CURRENT_ON  = 8'd3;
    localparam logic [7:0] LEVEL_VELOCITY_ON = 8'd4;
    localparam logic [7:0] LEVEL_ANGLE_ON    = 8'd5;

    // Loop bits in the enable and clear-integral masks
    localparam int LOOP_CURRENT  = 0;
    localparam int LOOP_VELOCITY = 1;
    localparam int LOOP_ANGLE    = 2;

    // Arithmetic constants
    localparam logic signed [10:0] MAX_DRIVE   = 11'sd1023;
    localparam int                 DRIVE_SHIFT = 7;   // divide by 128
    localparam int                 ANGLE_SHIFT = 6;   // divide by 64
    localparam logic signed [9:0]  ANGLE_LIMIT = 10'sd462;

    // Reset values
    localparam logic [7:0] SCALE_RESET  = 8'd128;
    localparam logic [7:0] CENTER_RESET = 8'd128;   // centre offset of zero

    typedef logic [7:0] gain_t;

    function automatic gain_t gain_default(input logic [GAIN_IDX_W-1:0] idx);
        gain_t g;
        case (idx)
            4'd0:    g = 8'd7;
            4'd1:    g = 8'd8;
            4'd2:    g = 8'd2;
            4'd3:    g = 8'd20;
            4'd4:    g = 8'd0;
            4'd5:    g = 8'd30;
            4'd6:    g = 8'd8;
            4'd7:    g = 8'd0;
            4'd8:    g = 8'd30;
            default: g = 8'd0;
        endcase
        return g;
    endfunction

    // Settings that shape the setpoint arithmetic
    typedef struct packed {
        logic       invert;
        logic       coil_inverted;
        logic [7:0] scale;
        logic [7:0] center;     // stored as the written byte
    } calc_ctrl_t;

    // Candidate setpoints for the current write byte
    typedef struct packed {
        logic signed [10:0] drive;
        logic signed [10:0] current;
        logic signed [10:0] velocity;
        logic signed [9:0]  angle;
    } setpoints_t;

endpackage

`default_nettype wire

/* hw/rtl/ssrf_if.sv */
// ============================================================================
// ssrf_if - servo setpoint register file channels
// Request, response and configuration channels, each valid/ready with a
// source and a sink side.
// ============================================================================
`default_nettype none

interface ssrf_req_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [4:0] address;
    logic [7:0] value;

    modport source (output valid, output action, output address, output value,
                    input ready);
    modport sink   (input valid, input action, input address, input value,
                    output ready);
endinterface

interface ssrf_rsp_if;
    logic               valid;
    logic               ready;
    logic [7:0]         read_data;
    logic signed [10:0] drive_level;
    logic signed [10:0] current_target;
    logic signed [10:0] velocity_target;
    logic signed [9:0]  angle_target;
    logic [2:0]         clear_integral;
    logic [2:0]         loop_enables;

    modport source (output valid, output read_data, output drive_level,
                    output current_target, output velocity_target,
                    output angle_target, output clear_integral,
                    output loop_enables, input ready);
    modport sink   (input valid, input read_data, input drive_level,
                    input current_target, input velocity_target,
                    input angle_target, input clear_integral,
                    input loop_enables, output ready);
endinterface

interface ssrf_cfg_if;
    logic valid;
    logic ready;
    logic coil_inverted;

    modport source (output valid, output coil_inverted, input ready);
    modport sink   (input valid, input coil_inverted, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ssrf_setpoint_calc.sv */
// ============================================================================
// ssrf_setpoint_calc - setpoint arithmetic
// Works out the drive level, current, velocity and angle setpoints that a
// write byte would produce under the present invert, scale and centre.
// ============================================================================
`default_nettype none

module ssrf_setpoint_calc (
    input  wire logic [7:0]          value,
    input  wire ssrf_pkg::calc_ctrl_t ctrl,
    output ssrf_pkg::setpoints_t      setpoints
);

    logic               flip;
    logic signed [8:0]  centred;
    logic signed [18:0] drive_prod;
    logic signed [18:0] drive_biased;
    logic signed [18:0] drive_quot;
    logic signed [10:0] drive_lvl;
    logic signed [10:0] linear_sp;
    logic signed [17:0] angle_prod;
    logic signed [17:0] angle_biased;
    logic signed [17:0] angle_quot;
    logic signed [11:0] angle_scaled;
    logic signed [11:0] center_off;
    logic signed [11:0] angle_sum;

    assign flip    = ctrl.invert ^ ctrl.coil_inverted;
    assign centred = $signed({1'b0, value}) - 9'sd128;

    // Drive: (byte-128)*MAX_DRIVE/128, rounded toward zero
    assign drive_prod   = 19'(centred) * 19'(ssrf_pkg::MAX_DRIVE);
    assign drive_biased = drive_prod
                        + (drive_prod[18] ? 19'sd127 : 19'sd0);
    assign drive_quot   = drive_biased >>> ssrf_pkg::DRIVE_SHIFT;
    assign drive_lvl    = drive_quot[10:0];

    assign linear_sp = $signed({1'b0, value, 2'b00}) - 11'sd512;

    // Angle: (byte-128)*scale/64 toward zero, invert, add centre, clamp
    assign angle_prod   = 18'(centred) * 18'($signed({1'b0, ctrl.scale}));
    assign angle_biased = angle_prod
                        + (angle_prod[17] ? 18'sd63 : 18'sd0);
    assign angle_quot   = angle_biased >>> ssrf_pkg::ANGLE_SHIFT;
    assign angle_scaled = ctrl.invert ? -angle_quot[11:0] : angle_quot[11:0];
    assign center_off   = $signed({2'b00, ctrl.center, 2'b00}) - 12'sd512;
    assign angle_sum    = angle_scaled + center_off;

    always_comb
    begin
        setpoints.drive    = flip ? -drive_lvl : drive_lvl;
        setpoints.current  = flip ? -linear_sp : linear_sp;
        setpoints.velocity = ctrl.invert ? -linear_sp : linear_sp;
        if (angle_sum > 12'(ssrf_pkg::ANGLE_LIMIT))
        begin
            setpoints.angle = ssrf_pkg::ANGLE_LIMIT;
        end
        else if (angle_sum < -12'(ssrf_pkg::ANGLE_LIMIT))
        begin
            setpoints.angle = -ssrf_pkg::ANGLE_LIMIT;
        end
        else
        begin
            setpoints.angle = angle_sum[9:0];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/servo_setpoint_register_file_unit.sv */
// ============================================================================
// servo_setpoint_register_file_unit - servo setpoint register file
// Byte-wide register front end of a three-loop servo controller: gains,
// angle centre/scale/invert, gated setpoint ports and the loop-enable level.
// ============================================================================
// Usage:
//   req carries one bus access (action, address, value). Each accepted
//   request yields exactly one response on rsp: the read-back byte, the
//   held drive level and setpoints, the one-shot clear-integral mask and
//   the loop enables, all as they stand after the access.
//   cfg writes the coil_inverted bit; it is always ready and should only be
//   written while no response is outstanding.
//   The response is registered: a request accepted in one cycle is
//   presented on rsp in the next. Throughput is one request per cycle
//   while rsp is not stalled, set by the single result register; decode,
//   the two small multiplies and the clamp all sit in front of it.
//   When rsp is stalled, req.ready drops and the response and all req-written
//   state hold; a request is taken in the same cycle the pending response leaves.
//   Reset loads the default gains, scale 128, centre offset and setpoints
//   zero, all loops off and coil_inverted clear; no response is pending.
// ============================================================================
`default_nettype none

module servo_setpoint_register_file_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ssrf_req_if.sink    req,
    ssrf_rsp_if.source  rsp,
    ssrf_cfg_if.sink    cfg
);

    logic                         accept;
    logic                         is_write;
    logic [ssrf_pkg::GAIN_IDX_W-1:0] gain_idx;

    ssrf_pkg::gain_t              gain_reg [ssrf_pkg::GAIN_COUNT];
    logic [7:0]                   center_reg;
    logic [7:0]                   scale_reg;
    logic                         invert_reg;
    logic                         coil_inv_reg;
    logic [2:0]                   enable_reg;
    logic [2:0]                   enable_next;
    logic signed [10:0]           drive_reg;
    logic signed [10:0]           current_reg;
    logic signed [10:0]           velocity_reg;
    logic signed [9:0]            angle_reg;
    logic                         rsp_valid_reg;
    logic [7:0]                   read_data_reg;
    logic [7:0]                   read_data_next;
    logic [2:0]                   clear_reg;
    logic [2:0]                   clear_next;

    ssrf_pkg::calc_ctrl_t         calc_ctrl;
    ssrf_pkg::setpoints_t         calc_sp;

    assign accept   = req.valid && req.ready;
    assign is_write = (req.action == ssrf_pkg::ACTION_WRITE);
    assign gain_idx = req.address[ssrf_pkg::GAIN_IDX_W-1:0];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign cfg.ready = 1'b1;

    assign calc_ctrl.invert        = invert_reg;
    assign calc_ctrl.coil_inverted = coil_inv_reg;
    assign calc_ctrl.scale         = scale_reg;
    assign calc_ctrl.center        = center_reg;

    ssrf_setpoint_calc u_calc (
        .value     (req.value),
        .ctrl      (calc_ctrl),
        .setpoints (calc_sp)
    );

    // Read-back reflects the register after this access
    always_comb
    begin
        read_data_next = 8'd0;
        clear_next     = 3'd0;
        unique case (req.address) inside
            [ssrf_pkg::ADDR_GAIN_FIRST:ssrf_pkg::ADDR_GAIN_LAST]:
            begin
                read_data_next = is_write ? req.value : gain_reg[gain_idx];
                if (is_write)
                begin
                    clear_next[ssrf_pkg::LOOP_CURRENT] =
                        (req.address == ssrf_pkg::ADDR_CUR_I);
                    clear_next[ssrf_pkg::LOOP_VELOCITY] =
                        (req.address == ssrf_pkg::ADDR_VEL_I);
                    clear_next[ssrf_pkg::LOOP_ANGLE] =
                        (req.address == ssrf_pkg::ADDR_ANG_I);
                end
            end
            ssrf_pkg::ADDR_CENTER:
            begin
                read_data_next = is_write ? req.value : center_reg;
            end
            ssrf_pkg::ADDR_SCALE:
            begin
                read_data_next = is_write ? req.value : scale_reg;
            end
            ssrf_pkg::ADDR_INVERT:
            begin
                read_data_next = {7'd0, is_write ? (req.value != 8'd0) : invert_reg};
            end
            default:
            begin
                read_data_next = 8'd0;
            end
        endcase
    end

    always_comb
    begin
        enable_next = 3'd0;
        enable_next[ssrf_pkg::LOOP_CURRENT]  = (req.value >= ssrf_pkg::LEVEL_CURRENT_ON);
        enable_next[ssrf_pkg::LOOP_VELOCITY] = (req.value >= ssrf_pkg::LEVEL_VELOCITY_ON);
        enable_next[ssrf_pkg::LOOP_ANGLE]    = (req.value >= ssrf_pkg::LEVEL_ANGLE_ON);
    end

    // Register state; setpoint ports act on writes only; all but the angle port obey loop gating
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ssrf_pkg::GAIN_COUNT; i++)
            begin
                gain_reg[i] <= ssrf_pkg::gain_default(ssrf_pkg::GAIN_IDX_W'(i));
            end
            center_reg   <= ssrf_pkg::CENTER_RESET;
            scale_reg    <= ssrf_pkg::SCALE_RESET;
            invert_reg   <= 1'b0;
            enable_reg   <= 3'd0;
            drive_reg    <= '0;
            current_reg  <= '0;
            velocity_reg <= '0;
            angle_reg    <= '0;
        end
        else if (accept && is_write)
        begin
            unique case (req.address) inside
                [ssrf_pkg::ADDR_GAIN_FIRST:ssrf_pkg::ADDR_GAIN_LAST]:
                begin
                    gain_reg[gain_idx] <= req.value;
                end
                ssrf_pkg::ADDR_CENTER:
                begin
                    center_reg <= req.value;
                end
                ssrf_pkg::ADDR_SCALE:
                begin
                    scale_reg <= req.value;
                end
                ssrf_pkg::ADDR_INVERT:
                begin
                    invert_reg <= (req.value != 8'd0);
                end
                ssrf_pkg::ADDR_DRIVE:
                begin
                    if (!enable_reg[ssrf_pkg::LOOP_CURRENT])
                    begin
                        drive_reg <= calc_sp.drive;
                    end
                end
                ssrf_pkg::ADDR_CURRENT:
                begin
                    if (!enable_reg[ssrf_pkg::LOOP_VELOCITY])
                    begin
                        current_reg <= calc_sp.current;
                    end
                end
                ssrf_pkg::ADDR_VELOCITY:
                begin
                    if (!enable_reg[ssrf_pkg::LOOP_ANGLE])
                    begin
                        velocity_reg <= calc_sp.velocity;
                    end
                end
                ssrf_pkg::ADDR_ANGLE:
                begin
                    angle_reg <= calc_sp.angle;
                end
                ssrf_pkg::ADDR_INIT:
                begin
                    enable_reg <= enable_next;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coil_inv_reg <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            coil_inv_reg <= cfg.coil_inverted;
        end
    end

    // Response register; hold while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            rsp_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_data_reg <= read_data_next;
            clear_reg     <= clear_next;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.read_data       = read_data_reg;
    assign rsp.clear_integral  = clear_reg;
    assign rsp.drive_level     = drive_reg;
    assign rsp.current_target  = current_reg;
    assign rsp.velocity_target = velocity_reg;
    assign rsp.angle_target    = angle_reg;
    assign rsp.loop_enables    = enable_reg;

    // ------------------------------------------------------------------------
    a_accept_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("accepted request produced no response");

    a_clear_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> $onehot0(clear_reg))
        else $error("more than one integral clear in one response");

    a_angle_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (angle_reg <= ssrf_pkg::ANGLE_LIMIT) && (angle_reg >= -ssrf_pkg::ANGLE_LIMIT))
        else $error("angle setpoint outside clamp range");

    a_enables_nested: assert property (@(posedge clk) disable iff (!rst_n)
        (enable_reg == 3'b000) || (enable_reg == 3'b001) ||
        (enable_reg == 3'b011) || (enable_reg == 3'b111))
        else $error("loop enables not nested");

endmodule

`default_nettype wire

/* tb/servo_setpoint_register_file_unit_checker.sv */
`timescale 1ns / 100ps
// ============================================================================
// servo_setpoint_register_file_unit_checker - response checker
// Watches the request, response and configuration channels. It keeps its own
// copy of the register file state, works out the response for each accepted
// request and compares every accepted response, field by field, against the
// oldest outstanding prediction.
// ============================================================================

module servo_setpoint_register_file_unit_checker (
    input  logic clk,
    input  logic rst_n,
    ssrf_req_if  req,
    ssrf_rsp_if  rsp,
    ssrf_cfg_if  cfg,
    output int   mismatch_count,
    output int   pending_count
);

    localparam int BYTE_MID     = 128;
    localparam int DRIVE_DIV    = 128;
    localparam int ANGLE_DIV    = 64;
    localparam int SETPOINT_OFS = 512;
    localparam int SETPOINT_MUL = 4;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [10:0] drive;
        logic [10:0] current;
        logic [10:0] velocity;
        logic [9:0]  angle;
        logic [2:0]  clear;
        logic [2:0]  enables;
    } access_result_t;

    access_result_t expected_responses [$];

    logic [7:0] gain_bank [ssrf_pkg::GAIN_COUNT];
    int         centre_offset;
    logic [7:0] angle_scale;
    logic       invert_flag;
    logic       coil_flip;
    logic [2:0] loops_on;
    int         drive_level;
    int         current_sp;
    int         velocity_sp;
    int         angle_sp;

    function automatic access_result_t apply_access(input logic act, input logic [4:0] addr,
                                                    input logic [7:0] val);
        access_result_t                   res;
        int                               b;
        int                               sp;
        logic                             flip;
        logic [ssrf_pkg::GAIN_IDX_W-1:0]  gidx;
        res  = '0;
        b    = int'(val);
        flip = invert_flag ^ coil_flip;
        gidx = addr[ssrf_pkg::GAIN_IDX_W-1:0];
        if (addr <= ssrf_pkg::ADDR_GAIN_LAST)
        begin
            if (act == ssrf_pkg::ACTION_WRITE)
            begin
                gain_bank[gidx] = val;
                if (addr == ssrf_pkg::ADDR_CUR_I)
                    res.clear[ssrf_pkg::LOOP_CURRENT] = 1'b1;
                else if (addr == ssrf_pkg::ADDR_VEL_I)
                    res.clear[ssrf_pkg::LOOP_VELOCITY] = 1'b1;
                else if (addr == ssrf_pkg::ADDR_ANG_I)
                    res.clear[ssrf_pkg::LOOP_ANGLE] = 1'b1;
            end
            res.read_data = gain_bank[gidx];
        end
        else if (addr == ssrf_pkg::ADDR_CENTER)
        begin
            if (act == ssrf_pkg::ACTION_WRITE)
                centre_offset = b * SETPOINT_MUL - SETPOINT_OFS;
            sp = (centre_offset + SETPOINT_OFS) / SETPOINT_MUL;
            res.read_data = sp[7:0];
        end
        else if (addr == ssrf_pkg::ADDR_SCALE)
        begin
            if (act == ssrf_pkg::ACTION_WRITE)
                angle_scale = val;
            res.read_data = angle_scale;
        end
        else if (addr == ssrf_pkg::ADDR_INVERT)
        begin
            if (act == ssrf_pkg::ACTION_WRITE)
                invert_flag = (val != 8'd0);
            res.read_data = {7'd0, invert_flag};
        end
        else if (act == ssrf_pkg::ACTION_WRITE)
        begin
            case (addr)
                ssrf_pkg::ADDR_DRIVE:
                    if (!loops_on[ssrf_pkg::LOOP_CURRENT])
                    begin
                        sp = (b - BYTE_MID) * int'(ssrf_pkg::MAX_DRIVE) / DRIVE_DIV;
                        drive_level = flip ? -sp : sp;
                    end
                ssrf_pkg::ADDR_CURRENT:
                    if (!loops_on[ssrf_pkg::LOOP_VELOCITY])
                    begin
                        sp = b * SETPOINT_MUL - SETPOINT_OFS;
                        current_sp = flip ? -sp : sp;
                    end
                ssrf_pkg::ADDR_VELOCITY:
                    if (!loops_on[ssrf_pkg::LOOP_ANGLE])
                    begin
                        sp = b * SETPOINT_MUL - SETPOINT_OFS;
                        velocity_sp = invert_flag ? -sp : sp;
                    end
                ssrf_pkg::ADDR_ANGLE:
                begin
                    sp = (b - BYTE_MID) * int'(angle_scale) / ANGLE_DIV;
                    if (invert_flag)
                        sp = -sp;
                    sp = sp + centre_offset;
                    if (sp > int'(ssrf_pkg::ANGLE_LIMIT))
                        sp = int'(ssrf_pkg::ANGLE_LIMIT);
                    else if (sp < -int'(ssrf_pkg::ANGLE_LIMIT))
                        sp = -int'(ssrf_pkg::ANGLE_LIMIT);
                    angle_sp = sp;
                end
                ssrf_pkg::ADDR_INIT:
                begin
                    loops_on[ssrf_pkg::LOOP_CURRENT]  = (val >= ssrf_pkg::LEVEL_CURRENT_ON);
                    loops_on[ssrf_pkg::LOOP_VELOCITY] = (val >= ssrf_pkg::LEVEL_VELOCITY_ON);
                    loops_on[ssrf_pkg::LOOP_ANGLE]    = (val >= ssrf_pkg::LEVEL_ANGLE_ON);
                end
                default: ;
            endcase
        end
        res.drive    = drive_level[10:0];
        res.current  = current_sp[10:0];
        res.velocity = velocity_sp[10:0];
        res.angle    = angle_sp[9:0];
        res.enables  = loops_on;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [10:0] exp_val,
                                        input logic [10:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, exp_val, act_val);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        access_result_t exp_res;
        if (!rst_n)
        begin
            gain_bank      = '{8'd7, 8'd8, 8'd2, 8'd20, 8'd0, 8'd30, 8'd8, 8'd0, 8'd30};
            centre_offset  = 0;
            angle_scale    = ssrf_pkg::SCALE_RESET;
            invert_flag    = 1'b0;
            coil_flip      = 1'b0;
            loops_on       = '0;
            drive_level    = 0;
            current_sp     = 0;
            velocity_sp    = 0;
            angle_sp       = 0;
            mismatch_count = 0;
            expected_responses.delete();
            pending_count  = 0;
        end
        else
        begin
            // Retire the leaving response before predicting the arriving request
            if (rsp.valid && rsp.ready)
            begin
                if (expected_responses.size() == 0)
                begin
                    $display("%0t: response with none expected, expected nothing actual 0x%0h",
                             $time, rsp.read_data);
                    mismatch_count++;
                end
                else
                begin
                    exp_res = expected_responses.pop_front();
                    check_field("read_data", 11'(exp_res.read_data), 11'(rsp.read_data));
                    check_field("drive_level", exp_res.drive, rsp.drive_level);
                    check_field("current_target", exp_res.current, rsp.current_target);
                    check_field("velocity_target", exp_res.velocity, rsp.velocity_target);
                    check_field("angle_target", 11'(exp_res.angle),
                                11'($unsigned(rsp.angle_target)));
                    check_field("clear_integral", 11'(exp_res.clear),
                                11'(rsp.clear_integral));
                    check_field("loop_enables", 11'(exp_res.enables),
                                11'(rsp.loop_enables));
                end
            end
            if (cfg.valid && cfg.ready)
                coil_flip = cfg.coil_inverted;
            if (req.valid && req.ready)
                expected_responses.push_back(apply_access(req.action, req.address, req.value));
            pending_count = expected_responses.size();
        end
    end

endmodule

/* tb/servo_setpoint_register_file_unit_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// servo_setpoint_register_file_unit_tb - register file testbench
// Drives bus accesses into the servo setpoint register file: a directed
// sweep of gains, centre, scale, invert, setpoint ports, loop gating and
// unmapped addresses, then random traffic under three idling profiles and
// both coil wiring settings. A long response hold-off fills the block.
// ============================================================================

module servo_setpoint_register_file_unit_tb;

    localparam int PHASE_ITEMS = 600;
    localparam int HOLD_CYCLES = 60;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int mismatch_count;
    int pending_count;

    ssrf_req_if req_ch ();
    ssrf_rsp_if rsp_ch ();
    ssrf_cfg_if cfg_ch ();

    servo_setpoint_register_file_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    servo_setpoint_register_file_unit_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .cfg            (cfg_ch),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Response side: random stalls, plus a counted hold-off on request
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left    = 0;
        hold_seen    = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic issue_access(input logic act, input logic [4:0] addr, input logic [7:0] val);
        int gap;
        gap = 0;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid   <= 1'b1;
        req_ch.action  <= act;
        req_ch.address <= addr;
        req_ch.value   <= val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain_responses();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        wait (pending_count == 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_coil_wiring(input logic inverted);
        drain_responses();
        @(negedge clk);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.coil_inverted <= inverted;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Bias towards setpoint ports and low init levels so the gating is exercised
    task automatic random_access();
        int         pick;
        logic       act;
        logic [4:0] addr;
        logic [7:0] val;
        pick = $urandom_range(99);
        act  = ($urandom_range(99) < 80) ? ssrf_pkg::ACTION_WRITE : ssrf_pkg::ACTION_READ;
        val  = 8'($urandom_range(255));
        if ($urandom_range(9) == 0)
            val = ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
        if (pick < 28)
        begin
            addr = 5'($urandom_range(ssrf_pkg::ADDR_DRIVE, ssrf_pkg::ADDR_ANGLE));
            if ($urandom_range(9) != 0)
                act = ssrf_pkg::ACTION_WRITE;
        end
        else if (pick < 38)
        begin
            addr = ssrf_pkg::ADDR_INIT;
            if ($urandom_range(4) != 0)
                val = 8'($urandom_range(6));
        end
        else if (pick < 63)
            addr = 5'($urandom_range(ssrf_pkg::ADDR_GAIN_FIRST, ssrf_pkg::ADDR_GAIN_LAST));
        else if (pick < 80)
        begin
            addr = 5'($urandom_range(ssrf_pkg::ADDR_CENTER, ssrf_pkg::ADDR_INVERT));
            if (addr == ssrf_pkg::ADDR_INVERT && $urandom_range(1) == 0)
                val = 8'd0;
        end
        else if (pick < 90)
            addr = 5'($urandom_range(17, 31));
        else
            addr = 5'($urandom_range(31));
        issue_access(act, addr, val);
    endtask

    initial
    begin
        req_ch.valid         <= 1'b0;
        req_ch.action        <= ssrf_pkg::ACTION_READ;
        req_ch.address       <= '0;
        req_ch.value         <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.coil_inverted <= 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        write_coil_wiring(1'b0);

        // Directed sweep
        issue_access(ssrf_pkg::ACTION_READ,  ssrf_pkg::ADDR_GAIN_FIRST, 8'd0);
        issue_access(ssrf_pkg::ACTION_WRITE, ssrf_pkg::ADDR_CUR_I,      8'd255);
        issue_access(ssrf_pkg::ACTION_WRITE, ssrf_pkg::ADDR_VEL_I,      8'd0);
        issue_access(ssrf_pkg::ACTION_WRITE, ssrf_pkg::ADDR_ANG_I,      8'd128);
        issue_access(ssrf_pkg::ACTION_WRITE, ssrf_pkg::ADDR_GAIN_LAST,  8'd170);
        issue_access(ssrf_pkg::ACTION_WRITE, ssrf_pkg::ADDR_CENTER,     8'd0);
        issue_access(ssrf_pkg::ACTION_WRITE, ssrf_pkg::ADDR_ANGLE,      8'd0);
        issue_access(ssrf_pkg::ACTION_WRITE, ssrf_pkg::ADDR_CENTER,     8'd255);
        issue_access(ssrf_pkg::ACTION_WRITE, ssrf_pkg::ADDR_SCALE,      8'd255);
        issue_access(ssrf_pkg::ACTION_WRITE, ssrf_pkg::ADDR_ANGLE,      8'd255);
        issue_access(ssrf_pkg::ACTION_WRITE, ssrf_pkg::ADDR_INVERT,     8'd85);
        issue_access(ssrf_pkg::ACTION_READ,  ssrf_pkg::ADDR_INVERT,     8'd0);
        issue_access(ssrf_pkg::ACTION_WRITE, ssrf_pkg::ADDR_ANGLE,      8'd1);
        issue_access(ssrf_pkg::ACTION_WRITE, ssrf_pkg::ADDR_DRIVE,      8'd0);
        issue_access(ssrf_pkg::ACTION_WRITE, ssrf_pkg::ADDR_CURRENT,    8'd255);
        issue_access(ssrf_pkg::ACTION_WRITE, ssrf_pkg::ADDR_VELOCITY,   8'd0);
        issue_access(ssrf_pkg::ACTION_WRITE, ssrf_pkg::ADDR_INVERT,     8'd0);
        issue_access(ssrf_pkg::ACTION_WRITE, ssrf_pkg::ADDR_DRIVE,      8'd255);
        issue_access(ssrf_pkg::ACTION_READ,  ssrf_pkg::ADDR_VELOCITY,   8'd200);
        issue_access(ssrf_pkg::ACTION_WRITE, ssrf_pkg::ADDR_INIT,       8'd5);
        issue_access(ssrf_pkg::ACTION_WRITE, ssrf_pkg::ADDR_DRIVE,      8'd10);
        issue_access(ssrf_pkg::ACTION_WRITE, ssrf_pkg::ADDR_VELOCITY,   8'd77);
        issue_access(ssrf_pkg::ACTION_WRITE, 5'd31,                     8'd255);
        issue_access(ssrf_pkg::ACTION_READ,  ssrf_pkg::ADDR_CENTER,     8'd0);
        issue_access(ssrf_pkg::ACTION_WRITE, ssrf_pkg::ADDR_INIT,       8'd0);

        // Sender idles lightly, receiver heavily
        write_coil_wiring(1'b1);
        send_idle_pct  = 11;
        recv_stall_pct = 51;
        repeat (PHASE_ITEMS) random_access();

        // Roles swapped
        write_coil_wiring(1'b0);
        send_idle_pct  = 51;
        recv_stall_pct = 11;
        repeat (PHASE_ITEMS) random_access();

        // Full rate, opened by a long response hold-off to back the block up
        write_coil_wiring(1'b1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests++;
        repeat (PHASE_ITEMS) random_access();

        drain_responses();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/ssrf_pkg.sv
hw/rtl/ssrf_if.sv
hw/rtl/ssrf_setpoint_calc.sv
hw/rtl/servo_setpoint_register_file_unit.sv
tb/servo_setpoint_register_file_unit_checker.sv
tb/servo_setpoint_register_file_unit_tb.sv
